@@ src/rsd_pkg.sv @@
package rsd_pkg;

  // Batch capacity and derived widths
  localparam int MaxRecords = 64;
  localparam int CntW       = $clog2(MaxRecords + 1);

  // Fixed field widths
  localparam int BestW   = 20;
  localparam int PointsW = 24;
  localparam int GamesW  = 16;
  localparam int StatW   = 16;
  localparam int ArrW    = 6;
  localparam int DivCntW = $clog2(PointsW + 1);

  // Input transaction payload
  typedef struct packed {
    logic [BestW-1:0]   best_score;
    logic [PointsW-1:0] total_points;
    logic [GamesW-1:0]  games_played;
    logic [StatW-1:0]   player_hits;
    logic [StatW-1:0]   alien_hits;
    logic [StatW-1:0]   kills;
    logic [StatW-1:0]   times_killed;
    logic [BestW-1:0]   last_score;
    logic               final_record;
  } in_t;

  // Output transaction payload
  typedef struct packed {
    logic [ArrW-1:0]    record_number;
    logic [GamesW-1:0]  games_out;
    logic [PointsW-1:0] points_out;
    logic [StatW-1:0]   player_hits_out;
    logic [StatW-1:0]   alien_hits_out;
    logic [StatW-1:0]   kills_out;
    logic [StatW-1:0]   killed_out;
    logic [BestW-1:0]   best_out;
    logic [BestW-1:0]   last_out;
    logic [PointsW-1:0] average_score;
    logic               end_of_list;
  } out_t;

  // One stored record (150 bits)
  typedef struct packed {
    logic [ArrW-1:0]    arrival;
    logic [BestW-1:0]   best;
    logic [PointsW-1:0] points;
    logic [GamesW-1:0]  games;
    logic [StatW-1:0]   phits;
    logic [StatW-1:0]   ahits;
    logic [StatW-1:0]   kills;
    logic [StatW-1:0]   killed;
    logic [BestW-1:0]   last;
  } rec_t;

  // What a cell shows its neighbors
  typedef struct packed {
    rec_t rec;
    logic valid;
    logic disp;   // new record goes at or before this cell
  } link_t;

  // Commands broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
    logic clr;
  } cell_ctrl_t;

endpackage

@@ src/rsd_cell.sv @@
module rsd_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsd_pkg::cell_ctrl_t ctrl_i,
  input  rsd_pkg::rec_t      new_rec_i,
  input  rsd_pkg::link_t     left_i,
  input  rsd_pkg::link_t     right_i,
  output rsd_pkg::link_t     link_o
);

  rsd_pkg::rec_t rec_q, rec_d;
  logic          valid_q, valid_d;
  logic          disp;

  // Strictly larger key displaces, so equal keys stay in arrival order
  assign disp = !valid_q || (new_rec_i.best > rec_q.best);

  always_comb begin
    rec_d   = rec_q;
    valid_d = valid_q;
    priority if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      // shift toward the head
      rec_d   = right_i.rec;
      valid_d = right_i.valid;
    end else if (ctrl_i.ins && disp) begin
      // either take the new record or the one moving down from the left
      if (left_i.disp) begin
        rec_d   = left_i.rec;
        valid_d = left_i.valid;
      end else begin
        rec_d   = new_rec_i;
        valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign link_o.rec   = rec_q;
  assign link_o.valid = valid_q;
  assign link_o.disp  = disp;

endmodule

@@ src/rsd_divider.sv @@
module rsd_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rsd_pkg::PointsW-1:0] dividend_i,
  input  logic [rsd_pkg::GamesW-1:0]  divisor_i,
  output logic                        busy_o,
  output logic [rsd_pkg::PointsW-1:0] quotient_o
);

  logic [rsd_pkg::GamesW:0]        rem_q, rem_d;
  logic [rsd_pkg::PointsW-1:0]     quo_q, quo_d;
  logic [rsd_pkg::GamesW-1:0]      div_q, div_d;
  logic [rsd_pkg::DivCntW-1:0]     cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic [rsd_pkg::GamesW:0]        trial;
  logic                            fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_q[rsd_pkg::GamesW-1:0], quo_q[rsd_pkg::PointsW-1]};
  assign fits  = trial >= {1'b0, div_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
      cnt_d  = rsd_pkg::DivCntW'(rsd_pkg::PointsW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? (trial - {1'b0, div_q}) : trial;
      quo_d  = {quo_q[rsd_pkg::PointsW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      busy_d = (cnt_q != rsd_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

@@ src/record_sorter_descending_core.sv @@
// Channel | Direction | Handshake                 | Payload
// input   | in        | in_valid_i / in_stall_o   | in_data_i  (rsd_pkg::in_t)
// output  | out       | out_valid_o / out_stall_i | out_data_o (rsd_pkg::out_t)
//
// Loading accepts one record per cycle while idle; each of the first MaxRecords
// records is inserted in sorted place along the cell chain in the cycle it is
// accepted, and later ones are dropped. After the final record, zero-point
// records are skipped; each emitted one waits on the bit-serial 24-step divider.
// in_stall_o is high from the final record until the chain is emptied.
// Reset clears the cell valid bits, counters and state; no clearing pass.
module record_sorter_descending_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  rsd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rsd_pkg::out_t out_data_o
);

  typedef enum logic [1:0] {
    StIdle,
    StEmit,
    StDiv
  } state_e;

  state_e                   state_q;
  logic [rsd_pkg::CntW-1:0] count_q;
  logic [rsd_pkg::CntW-1:0] nz_q;
  rsd_pkg::rec_t            hold_q;
  logic                     out_valid_q;
  rsd_pkg::out_t            out_q;

  rsd_pkg::cell_ctrl_t      ctrl;
  rsd_pkg::rec_t            new_rec;
  rsd_pkg::link_t           links   [rsd_pkg::MaxRecords];
  rsd_pkg::link_t           left_in [rsd_pkg::MaxRecords];
  rsd_pkg::link_t           right_in[rsd_pkg::MaxRecords];

  logic                     accept;
  logic                     store;
  logic                     head_live;
  logic                     out_free;
  logic                     emit;
  logic                     div_start;
  logic                     div_busy;
  logic [rsd_pkg::PointsW-1:0] quotient;

  assign accept    = (state_q == StIdle) && in_valid_i;
  assign store     = accept && (count_q < rsd_pkg::CntW'(rsd_pkg::MaxRecords));
  assign head_live = links[0].rec.points != '0;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign emit      = (state_q == StDiv) && !div_busy && out_free;
  assign div_start = (state_q == StEmit) && (nz_q != '0) && head_live;

  // Incoming record with its arrival number
  always_comb begin
    new_rec.arrival = rsd_pkg::ArrW'(count_q);
    new_rec.best    = in_data_i.best_score;
    new_rec.points  = in_data_i.total_points;
    new_rec.games   = in_data_i.games_played;
    new_rec.phits   = in_data_i.player_hits;
    new_rec.ahits   = in_data_i.alien_hits;
    new_rec.kills   = in_data_i.kills;
    new_rec.killed  = in_data_i.times_killed;
    new_rec.last    = in_data_i.last_score;
  end

  // Chain commands
  always_comb begin
    ctrl.ins = store;
    ctrl.pop = (state_q == StEmit) && (nz_q != '0);
    ctrl.clr = (state_q == StEmit) && (nz_q == '0);
  end

  // Neighbor wiring
  for (genvar i = 0; i < rsd_pkg::MaxRecords; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_in[i] = '0;
    end else begin : g_mid
      assign left_in[i] = links[i-1];
    end
    if (i == rsd_pkg::MaxRecords - 1) begin : g_tail
      assign right_in[i] = '0;
    end else begin : g_body
      assign right_in[i] = links[i+1];
    end

    rsd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_rec_i (new_rec),
      .left_i    (left_in[i]),
      .right_i   (right_in[i]),
      .link_o    (links[i])
    );
  end

  rsd_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (links[0].rec.points),
    .divisor_i  (links[0].rec.games),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  // Control state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      nz_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // drop valid once taken, unless a new result replaces it
      if (out_valid_q && !out_stall_i && !emit) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (store) begin
            count_q <= count_q + 1'b1;
            if (in_data_i.total_points != '0) begin
              nz_q <= nz_q + 1'b1;
            end
          end
          if (accept && in_data_i.final_record) begin
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (nz_q == '0) begin
            count_q <= '0;
            state_q <= StIdle;
          end else if (head_live) begin
            hold_q  <= links[0].rec;
            state_q <= StDiv;
          end
        end
        StDiv: begin
          if (!div_busy && out_free) begin
            out_valid_q                 <= 1'b1;
            out_q.record_number         <= hold_q.arrival;
            out_q.games_out             <= hold_q.games;
            out_q.points_out            <= hold_q.points;
            out_q.player_hits_out       <= hold_q.phits;
            out_q.alien_hits_out        <= hold_q.ahits;
            out_q.kills_out             <= hold_q.kills;
            out_q.killed_out            <= hold_q.killed;
            out_q.best_out              <= hold_q.best;
            out_q.last_out              <= hold_q.last;
            out_q.average_score         <= (hold_q.games == '0) ? '0 : quotient;
            out_q.end_of_list           <= (nz_q == rsd_pkg::CntW'(1));
            nz_q                        <= nz_q - 1'b1;
            state_q                     <= StEmit;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  // Clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // DUT ports
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  rsd_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  rsd_pkg::out_t out_data_o;

  record_sorter_descending_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Records waiting to be sent, the predicted score board, and the ranked
  // results still owed by the block
  rsd_pkg::in_t  record_feed_q[$];
  rsd_pkg::rec_t board_q[$];
  rsd_pkg::out_t ranked_q[$];

  int  errors = 0;
  bit  calm_in = 1'b0;
  bit  calm_out = 1'b0;
  int  in_gap = 0;
  int  out_hold = 0;

  // Idle length for one transaction; calm stretches send back to back
  function automatic int draw_wait(input bit calm);
    if (calm) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Score board prediction: store, and on the final record rank and emit
  task automatic board_take(input rsd_pkg::in_t item);
    rsd_pkg::rec_t r;
    rsd_pkg::rec_t order[$];
    rsd_pkg::out_t o;
    int   k;
    int   last_idx;
    if (board_q.size() < rsd_pkg::MaxRecords) begin
      r.arrival = rsd_pkg::ArrW'(board_q.size());
      r.best    = item.best_score;
      r.points  = item.total_points;
      r.games   = item.games_played;
      r.phits   = item.player_hits;
      r.ahits   = item.alien_hits;
      r.kills   = item.kills;
      r.killed  = item.times_killed;
      r.last    = item.last_score;
      board_q.push_back(r);
    end
    if (item.final_record) begin
      // stable insertion, largest best score first
      foreach (board_q[i]) begin
        k = order.size();
        while (k > 0 && order[k-1].best < board_q[i].best) k--;
        order.insert(k, board_q[i]);
      end
      last_idx = -1;
      foreach (order[i]) if (order[i].points != '0) last_idx = i;
      foreach (order[i]) begin
        if (order[i].points != '0) begin
          o.record_number   = order[i].arrival;
          o.games_out       = order[i].games;
          o.points_out      = order[i].points;
          o.player_hits_out = order[i].phits;
          o.alien_hits_out  = order[i].ahits;
          o.kills_out       = order[i].kills;
          o.killed_out      = order[i].killed;
          o.best_out        = order[i].best;
          o.last_out        = order[i].last;
          o.average_score   = (order[i].games != '0) ?
                              rsd_pkg::PointsW'(order[i].points / order[i].games) : '0;
          o.end_of_list     = (i == last_idx);
          ranked_q.push_back(o);
        end
      end
      board_q.delete();
    end
  endtask

  task automatic check_field(input string name, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Driver: one record per transaction, random gaps between them
  always @(posedge clk_i) begin : driver
    int w;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else if (in_valid_i && !in_stall_o) begin
      board_take(in_data_i);
      if ($urandom_range(0, 24) == 0) calm_in = ~calm_in;
      w = draw_wait(calm_in);
      if (w == 0 && record_feed_q.size() > 0) begin
        in_data_i <= record_feed_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
        in_gap     <= w;
      end
    end else if (!in_valid_i) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (record_feed_q.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= record_feed_q.pop_front();
      end
    end
  end

  // Monitor: check each result transaction, stall at random
  always @(posedge clk_i) begin : monitor
    rsd_pkg::out_t want;
    int   w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_hold    <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      if (ranked_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_data_o);
      end else begin
        want = ranked_q.pop_front();
        check_field("record_number", want.record_number, out_data_o.record_number);
        check_field("games_out", want.games_out, out_data_o.games_out);
        check_field("points_out", want.points_out, out_data_o.points_out);
        check_field("player_hits_out", want.player_hits_out, out_data_o.player_hits_out);
        check_field("alien_hits_out", want.alien_hits_out, out_data_o.alien_hits_out);
        check_field("kills_out", want.kills_out, out_data_o.kills_out);
        check_field("killed_out", want.killed_out, out_data_o.killed_out);
        check_field("best_out", want.best_out, out_data_o.best_out);
        check_field("last_out", want.last_out, out_data_o.last_out);
        check_field("average_score", want.average_score, out_data_o.average_score);
        check_field("end_of_list", want.end_of_list, out_data_o.end_of_list);
      end
      if ($urandom_range(0, 24) == 0) calm_out = ~calm_out;
      w = draw_wait(calm_out);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        out_hold    <= w;
      end
    end else if (out_stall_i) begin
      if (out_hold > 1) out_hold <= out_hold - 1;
      else out_stall_i <= 1'b0;
    end else if (!calm_out && $urandom_range(0, 15) == 0) begin
      // stall also while nothing is offered
      out_stall_i <= 1'b1;
      out_hold    <= $urandom_range(1, 13);
    end
  end

  function automatic rsd_pkg::in_t mk_rec(input logic [19:0] best,
                                          input logic [23:0] points,
                                          input logic [15:0] games, input logic [15:0] stat,
                                          input logic [19:0] last, input logic fin);
    rsd_pkg::in_t it;
    it.best_score   = best;
    it.total_points = points;
    it.games_played = games;
    it.player_hits  = stat;
    it.alien_hits   = ~stat;
    it.kills        = stat;
    it.times_killed = ~stat;
    it.last_score   = last;
    it.final_record = fin;
    return it;
  endfunction

  // Random record; narrow key ranges make ties common
  function automatic rsd_pkg::in_t rand_rec(input bit fin, input int key_span);
    rsd_pkg::in_t it;
    it.best_score   = (key_span > 0) ? 20'($urandom_range(0, key_span)) : 20'($urandom);
    case ($urandom_range(0, 5))
      0:       it.total_points = '0;
      1:       it.total_points = 24'hFFFFFF;
      default: it.total_points = 24'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       it.games_played = '0;
      1, 2:    it.games_played = 16'($urandom_range(1, 20));
      3:       it.games_played = 16'hFFFF;
      default: it.games_played = 16'($urandom);
    endcase
    it.player_hits  = 16'($urandom);
    it.alien_hits   = 16'($urandom);
    it.kills        = 16'($urandom);
    it.times_killed = 16'($urandom);
    it.last_score   = 20'($urandom);
    it.final_record = fin;
    return it;
  endfunction

  // Stimulus and end of run
  initial begin : stimulus
    int sent;
    int size;
    int span;
    rsd_pkg::in_t it;

    // mixed batch: key extremes, ties, zero games, zero points, max average
    record_feed_q.push_back(mk_rec(20'hFFFFF, 24'hFFFFFF, 16'h0001, 16'hFFFF, 20'hFFFFF, 1'b0));
    record_feed_q.push_back(mk_rec(20'h00000, 24'h000001, 16'h0000, 16'h0000, 20'h00000, 1'b0));
    record_feed_q.push_back(mk_rec(20'd500, 24'h000000, 16'd3, 16'h00FF, 20'd9, 1'b0));
    record_feed_q.push_back(mk_rec(20'd500, 24'd100, 16'd7, 16'hFF00, 20'd11, 1'b0));
    record_feed_q.push_back(mk_rec(20'd500, 24'hFFFFFF, 16'hFFFF, 16'h5555, 20'h55555, 1'b0));
    record_feed_q.push_back(mk_rec(20'hFFFFF, 24'd2, 16'd3, 16'hAAAA, 20'h12345, 1'b0));
    record_feed_q.push_back(mk_rec(20'd1, 24'h800000, 16'h8000, 16'h0F0F, 20'hAAAAA, 1'b1));
    // every record with zero points: nothing emitted
    record_feed_q.push_back(mk_rec(20'd7, 24'd0, 16'd1, 16'h1234, 20'd1, 1'b0));
    record_feed_q.push_back(mk_rec(20'd9, 24'd0, 16'd0, 16'h4321, 20'd2, 1'b0));
    record_feed_q.push_back(mk_rec(20'd8, 24'd0, 16'd5, 16'hFFFF, 20'd3, 1'b1));
    // single record batch
    record_feed_q.push_back(mk_rec(20'd42, 24'd1000, 16'd10, 16'h0001, 20'd40, 1'b1));
    // lone final with zero points
    record_feed_q.push_back(mk_rec(20'hFFFFF, 24'd0, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 1'b1));
    // final sorts first but is skipped; end flag moves to the earlier record
    record_feed_q.push_back(mk_rec(20'd10, 24'd5, 16'd2, 16'h00AA, 20'd4, 1'b0));
    record_feed_q.push_back(mk_rec(20'd900, 24'd0, 16'd2, 16'hAA00, 20'd5, 1'b1));

    // random batches, a few of them filling or overflowing the store
    sent = record_feed_q.size();
    while (sent < 430) begin
      case ($urandom_range(0, 19))
        0:       size = rsd_pkg::MaxRecords + $urandom_range(1, 6);
        1:       size = rsd_pkg::MaxRecords;
        default: size = $urandom_range(1, 12);
      endcase
      span = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : 0;
      for (int i = 0; i < size; i++) begin
        it = rand_rec(i == size - 1, span);
        // dropped final of an overflow batch carries points, so a leak shows
        if (i == size - 1 && size > rsd_pkg::MaxRecords && it.total_points == '0)
          it.total_points = 24'd1;
        record_feed_q.push_back(it);
      end
      sent += size;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (record_feed_q.size() > 0 || in_valid_i || ranked_q.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
src/rsd_pkg.sv
src/rsd_cell.sv
src/rsd_divider.sv
src/record_sorter_descending_core.sv
bench/testbench.sv
